>>> design/btpc_pkg.sv
// ----------------------------------------------------------------------------
// Buzzer tone generator package
// Widths, constants and small helper functions shared by the tone generator
// and its serial arithmetic units.
// ----------------------------------------------------------------------------
package btpc_pkg;

    localparam int FREQ_W    = 15;
    localparam int VOL_W     = 7;
    localparam int DUR_W     = 19;
    localparam int ELAPSED_W = 29;
    localparam int SEG_W     = 16;
    localparam int TOGGLE_W  = 24;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 19;

    localparam int MUL_A_W = ELAPSED_W;
    localparam int MUL_B_W = FREQ_W;
    localparam int NUM_W   = MUL_A_W + MUL_B_W;
    localparam int DEN_W   = ELAPSED_W;
    localparam int QUO_W   = SEG_W;

    localparam int TICKS_PER_SECOND = 1000000;
    localparam int MS_TICKS         = 1000;
    localparam int FREQ_LO          = 20;
    localparam int FREQ_HI          = 20000;
    localparam int VOL_FULL         = 100;

    typedef logic [FREQ_W-1:0]    freq_t;
    typedef logic [VOL_W-1:0]     vol_t;
    typedef logic [DUR_W-1:0]     dur_t;
    typedef logic [ELAPSED_W-1:0] elapsed_t;
    typedef logic [SEG_W-1:0]     seg_t;
    typedef logic [TOGGLE_W-1:0]  toggle_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_DAT_W-1:0] cfg_data_t;
    typedef logic [NUM_W-1:0]     num_t;
    typedef logic [DEN_W-1:0]     den_t;
    typedef logic [QUO_W-1:0]     quo_t;

    localparam toggle_t TOGGLE_SAT = '1;

    localparam cfg_idx_t REG_TONE_FREQ      = 8'd0;
    localparam cfg_idx_t REG_CHIRP_END_FREQ = 8'd1;
    localparam cfg_idx_t REG_VOLUME         = 8'd2;
    localparam cfg_idx_t REG_DURATION_MS    = 8'd3;

    // Limits a signed frequency to the audible range.
    function automatic freq_t clamp_freq(input logic signed [17:0] f);
        freq_t r;
        if (f < $signed(18'(FREQ_LO))) begin
            r = FREQ_W'(FREQ_LO);
        end else if (f > $signed(18'(FREQ_HI))) begin
            r = FREQ_W'(FREQ_HI);
        end else begin
            r = f[FREQ_W-1:0];
        end
        return r;
    endfunction

    function automatic toggle_t sat_inc(input toggle_t t);
        toggle_t r;
        if (t == TOGGLE_SAT) begin
            r = t;
        end else begin
            r = t + toggle_t'(1);
        end
        return r;
    endfunction

endpackage

>>> design/buzzer_tone_pwm_chirp_generator.sv
// ----------------------------------------------------------------------------
// Buzzer tone, PWM and chirp generator
// Each input transfer is one tick; each tick returns one result transfer with
// the pin level, busy and finished flags and the saturating toggle count.
// ----------------------------------------------------------------------------
// One item is handled at a time. A tick that stays inside a segment passes
// the evaluate and put states into the result register. A tick that begins
// a new segment with a tone also runs the bit-serial units: a square wave a
// divide, PWM a divide, a multiply and a divide, and a chirp step a multiply
// and two divides; silence runs neither. All share one divider and one
// multiplier. The next item is accepted while the previous result waits in
// the output register. Configuration writes are always taken, with no wait.
module buzzer_tone_pwm_chirp_generator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_start_req,
    input  logic                s_abort,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_buzzer_level,
    output logic                m_busy_res,
    output logic                m_finished,
    output btpc_pkg::toggle_t   m_toggle_count,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  btpc_pkg::cfg_idx_t  cfg_index,
    input  btpc_pkg::cfg_data_t cfg_data
);
    import btpc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_SEG  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_PUT  = 3'd5;

    localparam logic [1:0] JOB_SWEEP  = 2'd0;
    localparam logic [1:0] JOB_PERIOD = 2'd1;
    localparam logic [1:0] JOB_DUTY   = 2'd2;

    freq_t tone_freq_reg;
    freq_t chirp_end_freq_reg;
    vol_t  volume_reg;
    dur_t  duration_ms_reg;

    logic [2:0] state_reg, state_next;
    logic [1:0] job_reg, job_next;
    logic       start_req_reg, start_req_next;
    logic       abort_reg, abort_next;
    logic       fin_reg, fin_next;
    elapsed_t   elapsed_reg, elapsed_next;
    seg_t       phase_reg, phase_next;
    seg_t       seg_len_reg, seg_len_next;
    seg_t       period_reg, period_next;
    logic       pin_reg, pin_next;
    logic       running_reg, running_next;
    toggle_t    toggles_reg, toggles_next;

    logic    m_valid_reg, m_valid_next;
    logic    out_level_reg, out_level_next;
    logic    out_busy_reg, out_busy_next;
    logic    out_fin_reg, out_fin_next;
    toggle_t out_toggles_reg, out_toggles_next;

    elapsed_t total_ticks;
    elapsed_t elapsed_inc;
    seg_t     phase_inc;
    freq_t    fs;
    logic     sweep_down;
    freq_t    mag;
    freq_t    fc;

    logic               mul_start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_done;
    num_t               mul_prod;
    logic               div_start;
    num_t               div_num;
    den_t               div_den;
    logic               div_done;
    quo_t               div_quo;

    btpc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    btpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_freq_reg      <= '0;
            chirp_end_freq_reg <= '0;
            volume_reg         <= VOL_W'(VOL_FULL);
            duration_ms_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TONE_FREQ:      tone_freq_reg      <= cfg_data[FREQ_W-1:0];
                REG_CHIRP_END_FREQ: chirp_end_freq_reg <= cfg_data[FREQ_W-1:0];
                REG_VOLUME:         volume_reg         <= cfg_data[VOL_W-1:0];
                REG_DURATION_MS:    duration_ms_reg    <= cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    assign total_ticks = ELAPSED_W'(duration_ms_reg) * ELAPSED_W'(MS_TICKS);
    assign elapsed_inc = elapsed_reg + elapsed_t'(1);
    assign phase_inc   = phase_reg + seg_t'(1);
    assign fs          = clamp_freq($signed({3'b000, tone_freq_reg}));
    assign sweep_down  = (chirp_end_freq_reg < fs);
    assign mag         = sweep_down ? (fs - chirp_end_freq_reg) : (chirp_end_freq_reg - fs);
    assign fc          = sweep_down
                       ? clamp_freq($signed({3'b000, fs}) - $signed({2'b00, div_quo}))
                       : clamp_freq($signed({3'b000, fs}) + $signed({2'b00, div_quo}));

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next       = state_reg;
        job_next         = job_reg;
        start_req_next   = start_req_reg;
        abort_next       = abort_reg;
        fin_next         = fin_reg;
        elapsed_next     = elapsed_reg;
        phase_next       = phase_reg;
        seg_len_next     = seg_len_reg;
        period_next      = period_reg;
        pin_next         = pin_reg;
        running_next     = running_reg;
        toggles_next     = toggles_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        out_level_next   = out_level_reg;
        out_busy_next    = out_busy_reg;
        out_fin_next     = out_fin_reg;
        out_toggles_next = out_toggles_reg;
        mul_start        = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        div_start        = 1'b0;
        div_num          = '0;
        div_den          = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    start_req_next = s_start_req;
                    abort_next     = s_abort;
                    state_next     = S_EVAL;
                end
            end
            S_EVAL: begin
                fin_next   = 1'b0;
                state_next = S_PUT;
                if (abort_reg) begin
                    if (running_reg) begin
                        running_next = 1'b0;
                        pin_next     = 1'b0;
                        phase_next   = '0;
                        seg_len_next = '0;
                        fin_next     = 1'b1;
                    end
                end else if (start_req_reg) begin
                    elapsed_next = '0;
                    toggles_next = '0;
                    pin_next     = 1'b0;
                    running_next = 1'b1;
                    if (total_ticks == '0) begin
                        running_next = 1'b0;
                        phase_next   = '0;
                        seg_len_next = '0;
                        fin_next     = 1'b1;
                    end else begin
                        state_next = S_SEG;
                    end
                end else if (running_reg) begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= total_ticks) begin
                        running_next = 1'b0;
                        pin_next     = 1'b0;
                        phase_next   = '0;
                        seg_len_next = '0;
                        fin_next     = 1'b1;
                    end else begin
                        phase_next = phase_inc;
                        if (phase_inc >= seg_len_reg) begin
                            state_next = S_SEG;
                        end
                    end
                end
            end
            S_SEG: begin
                phase_next = '0;
                if (tone_freq_reg == '0) begin
                    if (pin_reg) begin
                        pin_next     = 1'b0;
                        toggles_next = sat_inc(toggles_reg);
                    end
                    seg_len_next = '0;
                    state_next   = S_PUT;
                end else if (chirp_end_freq_reg != '0) begin
                    mul_start  = 1'b1;
                    mul_a      = elapsed_reg;
                    mul_b      = mag;
                    job_next   = JOB_SWEEP;
                    state_next = S_MUL;
                end else begin
                    div_start  = 1'b1;
                    div_num    = NUM_W'(TICKS_PER_SECOND);
                    div_den    = DEN_W'(fs);
                    job_next   = JOB_PERIOD;
                    state_next = S_DIV;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    div_num    = mul_prod;
                    div_den    = (job_reg == JOB_SWEEP) ? total_ticks : DEN_W'(VOL_FULL);
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    case (job_reg)
                        JOB_SWEEP: begin
                            div_start = 1'b1;
                            div_num   = NUM_W'(TICKS_PER_SECOND);
                            div_den   = DEN_W'(fc);
                            job_next  = JOB_PERIOD;
                        end
                        JOB_PERIOD: begin
                            if (chirp_end_freq_reg == '0 && volume_reg < VOL_W'(VOL_FULL)) begin
                                period_next = div_quo;
                                mul_start   = 1'b1;
                                mul_a       = MUL_A_W'(div_quo);
                                mul_b       = MUL_B_W'(volume_reg);
                                job_next    = JOB_DUTY;
                                state_next  = S_MUL;
                            end else begin
                                pin_next     = !pin_reg;
                                toggles_next = sat_inc(toggles_reg);
                                seg_len_next = {1'b0, div_quo[QUO_W-1:1]};
                                state_next   = S_PUT;
                            end
                        end
                        JOB_DUTY: begin
                            if (pin_reg) begin
                                pin_next     = 1'b0;
                                toggles_next = sat_inc(toggles_reg);
                                seg_len_next = period_reg - div_quo;
                            end else if (div_quo != '0) begin
                                pin_next     = 1'b1;
                                toggles_next = sat_inc(toggles_reg);
                                seg_len_next = div_quo;
                            end else begin
                                seg_len_next = period_reg;
                            end
                            state_next = S_PUT;
                        end
                        default: begin
                            state_next = S_PUT;
                        end
                    endcase
                end
            end
            S_PUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    out_level_next   = pin_reg;
                    out_busy_next    = running_reg;
                    out_fin_next     = fin_reg;
                    out_toggles_next = toggles_reg;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            job_reg     <= JOB_SWEEP;
            elapsed_reg <= '0;
            phase_reg   <= '0;
            seg_len_reg <= '0;
            pin_reg     <= 1'b0;
            running_reg <= 1'b0;
            toggles_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            job_reg     <= job_next;
            elapsed_reg <= elapsed_next;
            phase_reg   <= phase_next;
            seg_len_reg <= seg_len_next;
            pin_reg     <= pin_next;
            running_reg <= running_next;
            toggles_reg <= toggles_next;
            m_valid_reg <= m_valid_next;
        end
        start_req_reg   <= start_req_next;
        abort_reg       <= abort_next;
        fin_reg         <= fin_next;
        period_reg      <= period_next;
        out_level_reg   <= out_level_next;
        out_busy_reg    <= out_busy_next;
        out_fin_reg     <= out_fin_next;
        out_toggles_reg <= out_toggles_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_buzzer_level = out_level_reg;
    assign m_busy_res     = out_busy_reg;
    assign m_finished     = out_fin_reg;
    assign m_toggle_count = out_toggles_reg;

endmodule

>>> design/btpc_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-and-add multiplier that consumes one multiplier bit per cycle, most
// significant bit first, and pulses done when the product is ready.
// ----------------------------------------------------------------------------
module btpc_mul (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [btpc_pkg::MUL_A_W-1:0]         a,
    input  logic [btpc_pkg::MUL_B_W-1:0]         b,
    output logic                                 done,
    output btpc_pkg::num_t                       prod
);
    import btpc_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    num_t               acc_reg, acc_next;
    logic [MUL_A_W-1:0] a_reg, a_next;
    logic [MUL_B_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;

    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next = '0;
            a_next   = a;
            b_next   = b;
            cnt_next = CNT_W'(MUL_B_W);
        end else if (cnt_reg != '0) begin
            acc_next  = {acc_reg[NUM_W-2:0], 1'b0} + (b_reg[MUL_B_W-1] ? NUM_W'(a_reg) : '0);
            b_next    = {b_reg[MUL_B_W-2:0], 1'b0};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> design/btpc_div.sv
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring divider producing one quotient bit per cycle. The caller
// guarantees that the quotient fits in the quotient width.
// ----------------------------------------------------------------------------
module btpc_div (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  btpc_pkg::num_t num,
    input  btpc_pkg::den_t den,
    output logic           done,
    output btpc_pkg::quo_t quo
);
    import btpc_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    den_t             rem_reg, rem_next;
    den_t             den_reg, den_next;
    quo_t             quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = DEN_W'(num[NUM_W-1:QUO_W]);
            quo_next = num[QUO_W-1:0];
            den_next = den;
            cnt_next = CNT_W'(QUO_W);
        end else if (cnt_reg != '0) begin
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next  = {quo_reg[QUO_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> design/btpc_chk.sv
// ----------------------------------------------------------------------------
// Buzzer tone generator checker
// Port-level assertions for the tone generator, attached by a bind.
// ----------------------------------------------------------------------------
module btpc_chk (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_buzzer_level,
    input logic              m_busy_res,
    input logic              m_finished,
    input btpc_pkg::toggle_t m_toggle_count
);
    import btpc_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_buzzer_level) && $stable(m_busy_res)
            && $stable(m_finished) && $stable(m_toggle_count))
        else $error("result changed while stalled");

    a_fin_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_finished |-> !m_busy_res && !m_buzzer_level)
        else $error("finished result shows a running tone or a high pin");

    a_idle_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> !m_buzzer_level)
        else $error("pin high while no tone is running");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer taken while an item is in work");

endmodule

bind buzzer_tone_pwm_chirp_generator btpc_chk u_btpc_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_buzzer_level (m_buzzer_level),
    .m_busy_res     (m_busy_res),
    .m_finished     (m_finished),
    .m_toggle_count (m_toggle_count)
);

>>> bench/buzzer_tone_pwm_chirp_generator_checker.sv
// ----------------------------------------------------------------------------
// Buzzer tone generator checker
// Watches the tick, result and register channels of the tone generator. It
// keeps its own copy of the tone state and registers, works out the result of
// every accepted tick and compares each result transfer field by field with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module buzzer_tone_pwm_chirp_generator_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                s_start_req,
    input  logic                s_abort,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic                m_buzzer_level,
    input  logic                m_busy_res,
    input  logic                m_finished,
    input  btpc_pkg::toggle_t   m_toggle_count,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  btpc_pkg::cfg_idx_t  cfg_index,
    input  btpc_pkg::cfg_data_t cfg_data,
    output int                  pending,
    output logic                tone_on,
    output int                  failures
);
    timeunit 1ns;
    timeprecision 1ps;

    import btpc_pkg::*;

    typedef struct packed {
        logic    level;
        logic    busy;
        logic    fin;
        toggle_t toggles;
    } pin_report_t;

    pin_report_t pin_reports_due[$];

    freq_t    cf_tone;
    freq_t    cf_chirp;
    vol_t     cf_vol;
    dur_t     cf_dur;
    elapsed_t t_elapsed;
    seg_t     t_phase;
    seg_t     t_seg;
    logic     t_pin;
    logic     t_run;
    toggle_t  t_toggles;

    initial begin
        pending  = 0;
        failures = 0;
        tone_on  = 1'b0;
    end

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns checker: %s got %0d expected %0d", $time, what, got, want);
        failures++;
    endtask

    function automatic logic [31:0] tone_ticks();
        return 32'(cf_dur) * 32'd1000;
    endfunction

    function automatic int unsigned clamp_hz(input longint f);
        if (f < FREQ_LO) begin
            return FREQ_LO;
        end else if (f > FREQ_HI) begin
            return FREQ_HI;
        end
        return int'(f);
    endfunction

    task automatic drive_pin(input logic lvl);
        if (t_pin != lvl) begin
            t_pin = lvl;
            if (t_toggles != TOGGLE_SAT) begin
                t_toggles = t_toggles + toggle_t'(1);
            end
        end
    endtask

    task automatic halt_tone();
        t_run   = 1'b0;
        t_pin   = 1'b0;
        t_phase = '0;
        t_seg   = '0;
    endtask

    task automatic begin_segment();
        int unsigned         fs;
        int unsigned         fc;
        int unsigned         per;
        int unsigned         hi;
        longint              diff;
        longint unsigned     mag;
        longint unsigned     tot;
        longint unsigned     q;
        logic [31:0]         seg;
        t_phase = '0;
        seg = '0;
        if (cf_tone == '0) begin
            drive_pin(1'b0);
        end else begin
            fs = clamp_hz(longint'(cf_tone));
            if (cf_chirp != '0) begin
                diff = longint'(cf_chirp) - longint'(fs);
                mag  = (diff < 0) ? -diff : diff;
                tot  = tone_ticks();
                q    = (tot != 0) ? (mag * t_elapsed) / tot : 0;
                if (diff < 0) begin
                    fc = clamp_hz(longint'(fs) - longint'(q));
                end else begin
                    fc = clamp_hz(longint'(fs) + longint'(q));
                end
                drive_pin(!t_pin);
                seg = (TICKS_PER_SECOND / fc) / 2;
            end else if (cf_vol < VOL_FULL) begin
                per = TICKS_PER_SECOND / fs;
                hi  = per * cf_vol / VOL_FULL;
                if (t_pin) begin
                    drive_pin(1'b0);
                    seg = per - hi;
                end else if (hi > 0) begin
                    drive_pin(1'b1);
                    seg = hi;
                end else begin
                    seg = per;
                end
            end else begin
                drive_pin(!t_pin);
                seg = (TICKS_PER_SECOND / fs) / 2;
            end
        end
        t_seg = seg[SEG_W-1:0];
    endtask

    task automatic advance_tick(input logic start, input logic abrt, output pin_report_t r);
        logic fin;
        fin = 1'b0;
        if (abrt) begin
            if (t_run) begin
                halt_tone();
                fin = 1'b1;
            end
        end else if (start) begin
            t_elapsed = '0;
            t_toggles = '0;
            t_pin     = 1'b0;
            t_run     = 1'b1;
            if (tone_ticks() == 0) begin
                halt_tone();
                fin = 1'b1;
            end else begin
                begin_segment();
            end
        end else if (t_run) begin
            t_elapsed = t_elapsed + elapsed_t'(1);
            if (32'(t_elapsed) >= tone_ticks()) begin
                halt_tone();
                fin = 1'b1;
            end else begin
                t_phase = t_phase + seg_t'(1);
                if (t_phase >= t_seg) begin
                    begin_segment();
                end
            end
        end
        r.level   = t_pin;
        r.busy    = t_run;
        r.fin     = fin;
        r.toggles = t_toggles;
    endtask

    always @(posedge aclk) begin
        pin_report_t want;
        pin_report_t fresh;
        if (!aresetn) begin
            cf_tone   = '0;
            cf_chirp  = '0;
            cf_vol    = vol_t'(VOL_FULL);
            cf_dur    = '0;
            t_elapsed = '0;
            t_toggles = '0;
            halt_tone();
            pin_reports_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pin_reports_due.size() == 0) begin
                    flag_mismatch("result transfer with no tick outstanding", 1, 0);
                end else begin
                    want = pin_reports_due.pop_front();
                    if (m_buzzer_level !== want.level) begin
                        flag_mismatch("buzzer_level", m_buzzer_level, want.level);
                    end
                    if (m_busy_res !== want.busy) begin
                        flag_mismatch("busy_res", m_busy_res, want.busy);
                    end
                    if (m_finished !== want.fin) begin
                        flag_mismatch("finished", m_finished, want.fin);
                    end
                    if (m_toggle_count !== want.toggles) begin
                        flag_mismatch("toggle_count", m_toggle_count, want.toggles);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TONE_FREQ: begin
                        cf_tone = cfg_data[FREQ_W-1:0];
                    end
                    REG_CHIRP_END_FREQ: begin
                        cf_chirp = cfg_data[FREQ_W-1:0];
                    end
                    REG_VOLUME: begin
                        cf_vol = cfg_data[VOL_W-1:0];
                    end
                    REG_DURATION_MS: begin
                        cf_dur = cfg_data[DUR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                advance_tick(s_start_req, s_abort, fresh);
                pin_reports_due.push_back(fresh);
            end
        end
        pending = pin_reports_due.size();
        tone_on = t_run;
    end

endmodule

>>> bench/buzzer_tone_pwm_chirp_generator_tb.sv
// ----------------------------------------------------------------------------
// Buzzer tone generator testbench
// Drives microsecond ticks and register writes into the tone generator: a
// short directed sequence for the corner cases, then random register settings
// with long runs of ticks, random gaps and stalls on both channels, and two
// long result hold-offs. The checker predicts and compares; this module gives
// the verdict.
// ----------------------------------------------------------------------------
module buzzer_tone_pwm_chirp_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import btpc_pkg::*;

    localparam int       RANDOM_TICKS = 1800;
    localparam int       CYCLE_LIMIT  = 3000000;
    localparam int       HOLD_CYCLES  = 400;
    localparam cfg_idx_t NO_REG       = 8'hFF;
    localparam int       FREQ_TOP     = 32767;
    localparam int       DUR_TOP      = 524287;
    localparam int       VOL_TOP      = 127;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    logic      s_start_req;
    logic      s_abort;
    logic      m_valid;
    logic      m_ready;
    logic      m_buzzer_level;
    logic      m_busy_res;
    logic      m_finished;
    toggle_t   m_toggle_count;
    logic      cfg_valid;
    logic      cfg_ready;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    int   pending;
    int   failures;
    logic tone_on;
    int   cycles;
    int   results_seen;
    bit   sender_calm;

    buzzer_tone_pwm_chirp_generator DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_req    (s_start_req),
        .s_abort        (s_abort),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_buzzer_level (m_buzzer_level),
        .m_busy_res     (m_busy_res),
        .m_finished     (m_finished),
        .m_toggle_count (m_toggle_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    buzzer_tone_pwm_chirp_generator_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_req    (s_start_req),
        .s_abort        (s_abort),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_buzzer_level (m_buzzer_level),
        .m_busy_res     (m_busy_res),
        .m_finished     (m_finished),
        .m_toggle_count (m_toggle_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pending        (pending),
        .tone_on        (tone_on),
        .failures       (failures)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        results_seen = 0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (m_valid && m_ready) begin
            results_seen++;
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("buzzer_tone_pwm_chirp_generator_tb: FAIL");
            $finish;
        end
    end

    // The result side: random stalls, calm windows, and two long hold-offs.
    initial begin
        int  stall_left;
        int  window;
        int  r;
        bit  calm;
        bit  held_first;
        bit  held_second;
        stall_left  = 0;
        window      = 0;
        calm        = 1'b0;
        held_first  = 1'b0;
        held_second = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (window == 0) begin
                calm   = ($urandom_range(99) < 30);
                window = $urandom_range(300, 50);
            end
            window--;
            if (!held_first && results_seen >= 400) begin
                held_first = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (!held_second && results_seen >= 1300) begin
                held_second = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(99);
                if (r < 70) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    stall_left = (r < 97) ? $urandom_range(3) : $urandom_range(60, 20);
                end
            end
        end
    end

    function automatic int pause_len();
        int r;
        r = $urandom_range(99);
        if (sender_calm || r < 65) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(50, 10);
    endfunction

    task automatic send_tick(input logic start, input logic abrt);
        int g;
        s_valid     <= 1'b1;
        s_start_req <= start;
        s_abort     <= abrt;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        g = pause_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= cfg_data_t'(value);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic set_tone(input int tone, input int chirp, input int vol, input int dur);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        write_reg(REG_TONE_FREQ, tone);
        write_reg(REG_CHIRP_END_FREQ, chirp);
        write_reg(REG_VOLUME, vol);
        write_reg(REG_DURATION_MS, dur);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_freq();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            return 0;
        end else if (r < 14) begin
            return FREQ_LO;
        end else if (r < 18) begin
            return $urandom_range(FREQ_LO - 1, 1);
        end else if (r < 28) begin
            return FREQ_HI;
        end else if (r < 33) begin
            return FREQ_TOP;
        end else if (r < 43) begin
            return $urandom_range(FREQ_TOP, 1);
        end else if (r < 55) begin
            return $urandom_range(2000, FREQ_LO);
        end
        return $urandom_range(FREQ_HI, 2000);
    endfunction

    function automatic int pick_volume();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            return 0;
        end else if (r < 15) begin
            return 1;
        end else if (r < 25) begin
            return VOL_FULL - 1;
        end else if (r < 45) begin
            return VOL_FULL;
        end else if (r < 52) begin
            return VOL_TOP;
        end
        return $urandom_range(VOL_TOP);
    endfunction

    function automatic int pick_duration();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            return 0;
        end else if (r < 73) begin
            return 1;
        end else if (r < 85) begin
            return 2;
        end else if (r < 90) begin
            return DUR_TOP;
        end
        return $urandom_range(DUR_TOP);
    endfunction

    initial begin
        int  done_ticks;
        int  n;
        int  r;
        bit  noisy;
        logic st;
        logic ab;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_start_req = 1'b0;
        s_abort     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        sender_calm = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Zero duration, then abort while idle, alone and together with a start.
        set_tone(FREQ_HI, 0, VOL_FULL, 0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);

        // Square wave, restart while running, and abort winning over a start.
        set_tone(FREQ_HI, 0, VOL_FULL, 1);
        send_tick(1'b1, 1'b0);
        repeat (3) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        repeat (2) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);

        // Zero volume gives no pulse at all.
        set_tone(FREQ_HI, 0, 0, 1);
        send_tick(1'b1, 1'b0);
        repeat (2) send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);

        // Start and end frequencies beyond the audible range.
        set_tone(FREQ_TOP, FREQ_TOP, VOL_TOP, DUR_TOP);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        write_reg(NO_REG, DUR_TOP);
        cfg_valid <= 1'b0;
        send_tick(1'b0, 1'b0);

        done_ticks = 0;
        while (done_ticks < RANDOM_TICKS) begin
            set_tone(pick_freq(), ($urandom_range(99) < 35) ? 0 : pick_freq(),
                     pick_volume(), pick_duration());
            sender_calm = ($urandom_range(99) < 30);
            noisy = ($urandom_range(99) < 10);
            n = ($urandom_range(99) < 80) ? $urandom_range(500, 120) : $urandom_range(40, 5);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(999);
                if (noisy) begin
                    st = ($urandom_range(99) < 5);
                    ab = ($urandom_range(99) < 5);
                end else begin
                    ab = (r < 3);
                    st = (r < 1) || (r >= 3 && r < 6);
                end
                if (i == 0 && !noisy) begin
                    if ((!tone_on && $urandom_range(9) != 0) || $urandom_range(3) == 0) begin
                        st = 1'b1;
                        ab = 1'b0;
                    end
                end
                done_ticks++;
                send_tick(st, ab);
            end
        end

        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (failures == 0) begin
            $display("buzzer_tone_pwm_chirp_generator_tb: PASS");
        end else begin
            $display("buzzer_tone_pwm_chirp_generator_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
design/btpc_pkg.sv
design/btpc_mul.sv
design/btpc_div.sv
design/buzzer_tone_pwm_chirp_generator.sv
design/btpc_chk.sv
bench/buzzer_tone_pwm_chirp_generator_checker.sv
bench/buzzer_tone_pwm_chirp_generator_tb.sv
